[sv/sss_pkg.sv]
// Shared types and constants for the string splitter stream block.
// Used by sss_cell, sss_outq and string_splitter_stream; no dependencies.
package sss_pkg;

    localparam int BYTE_W      = 8;
    localparam int NUM_CELLS   = 8;
    localparam int CELL_IDX_W  = $clog2(NUM_CELLS);
    localparam int DLEN_W      = 4;
    localparam int DELIM_W     = NUM_CELLS * BYTE_W;
    localparam int OFF_W       = 17;
    localparam int POS_W       = 16;
    localparam int LIMIT_W     = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
    localparam int OUT_DATA_W  = 72;
    localparam int OUT_USER_W  = 2;

    localparam logic [BYTE_W-1:0] SPACE_BYTE   = 8'h20;
    localparam logic [OFF_W-1:0]  OFF_SAT      = 17'h10000;
    localparam logic [POS_W-1:0]  POS_SAT      = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELIM_BYTES  = 2'd0,
        CFG_DELIM_LENGTH = 2'd1,
        CFG_TOKEN_LIMIT  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic             token_valid;
        logic [POS_W-1:0] token_start;
        logic [OFF_W-1:0] token_length;
        logic [POS_W-1:0] token_index;
        logic             string_done;
        logic [OFF_W-1:0] token_total;
        logic             too_long;
        logic             last_of_run;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

[sv/sss_cell.sv]
// One cell of the recent-byte window: holds a byte and compares the byte
// moving into it against its delimiter byte. Depends on sss_pkg.
module sss_cell import sss_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  logic              i_clear,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic [BYTE_W-1:0] i_want,
    input  logic              i_care,
    output logic [BYTE_W-1:0] o_byte,
    output logic              o_match
);

    logic [BYTE_W-1:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_byte <= '0;
        end else if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte  = r_byte;
    assign o_match = !i_care || (i_byte == i_want);

endmodule

[sv/sss_outq.sv]
// Result queue: takes up to two results a cycle and delivers one a cycle when popped.
// Depends on sss_pkg.
module sss_outq import sss_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_data
);

    t_result              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr;
    logic [Q_PTR_W-1:0]   r_rd;
    logic [Q_CNT_W-1:0]   r_count;
    logic [Q_CNT_W-1:0]   n_count;
    logic                 pop;

    assign o_valid = (r_count != '0);
    assign o_ready = (r_count <= Q_CNT_W'(Q_DEPTH - 2));
    assign o_data  = r_mem[r_rd];
    assign pop     = o_valid && i_pop;
    assign n_count = r_count + Q_CNT_W'(i_push.count) - Q_CNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr + Q_PTR_W'(1)] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + Q_PTR_W'(i_push.count);
            r_rd    <= r_rd + Q_PTR_W'(pop);
            r_count <= n_count;
        end
    end

endmodule

[sv/string_splitter_stream.sv]
// String splitter stream: splits byte strings into tokens (start, length).
// Throughput: one byte per cycle while the result queue has room; only a string's final byte causes two results.
// Results queue in four entries, one leaves per tready cycle; input stalls while more than two wait.
// A byte's first result reaches the output in the cycle after the byte is accepted, if the queue is empty.
// Reset: synchronous, active low; clears configuration and string state.
// Depends on sss_pkg, sss_cell and sss_outq.
module string_splitter_stream import sss_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [DELIM_W-1:0]    i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [BYTE_W-1:0]     s_axis_tdata,   // data_byte
    input  logic                  s_axis_tlast,   // end_of_string
    input  logic                  s_axis_tuser,   // empty_string
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // token_start, token_length, token_index, token_total, last_of_run, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast,   // string_done
    output logic [OUT_USER_W-1:0] m_axis_tuser    // token_valid, too_long
);

    logic [DELIM_W-1:0]  r_delim;
    logic [DLEN_W-1:0]   r_dlen;
    logic [LIMIT_W-1:0]  r_limit;

    logic [OFF_W-1:0]    r_off, n_off;
    logic [OFF_W-1:0]    r_start, n_start;
    logic [OFF_W-1:0]    r_tok, n_tok;
    logic                r_inside, n_inside;
    logic [DLEN_W-1:0]   r_mbc, n_mbc;
    logic [POS_W-1:0]    r_lns, n_lns;
    logic                r_limreach, n_limreach;
    logic                r_too_long, n_too_long;

    logic                in_acc;
    logic                clear;
    logic [DLEN_W-1:0]   dlen;
    logic [BYTE_W-1:0]   cell_in   [NUM_CELLS];
    logic [BYTE_W-1:0]   cell_out  [NUM_CELLS];
    logic [BYTE_W-1:0]   cell_want [NUM_CELLS];
    logic [NUM_CELLS-1:0] cell_care;
    logic [NUM_CELLS-1:0] cell_match;

    t_push               push;
    logic                q_ready;
    t_result             q_data;

    function automatic logic [OFF_W-1:0] tok_inc(input logic [OFF_W-1:0] x);
        return (x == OFF_SAT) ? x : x + OFF_W'(1);
    endfunction

    function automatic t_result mk_token(input logic             valid,
                                         input logic [OFF_W-1:0] start,
                                         input logic [OFF_W-1:0] len,
                                         input logic [OFF_W-1:0] idx,
                                         input logic             tl);
        t_result r;
        r             = '0;
        r.token_valid = valid;
        r.too_long    = tl;
        if (valid) begin
            r.token_start  = start[OFF_W-1] ? POS_SAT : start[POS_W-1:0];
            r.token_length = len;
            r.token_index  = idx[OFF_W-1] ? POS_SAT : idx[POS_W-1:0];
        end
        return r;
    endfunction

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = q_ready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign dlen          = (r_dlen > DLEN_W'(NUM_CELLS)) ? DLEN_W'(NUM_CELLS) : r_dlen;

    always_comb begin
        logic [DLEN_W-1:0] sel;
        for (int j = 0; j < NUM_CELLS; j++) begin
            sel          = dlen - DLEN_W'(j) - DLEN_W'(1);
            cell_want[j] = r_delim[{sel[CELL_IDX_W-1:0], 3'b000} +: BYTE_W];
            cell_care[j] = DLEN_W'(j) < dlen;
            cell_in[j]   = (j == 0) ? s_axis_tdata : cell_out[(j == 0) ? 0 : j - 1];
        end
    end

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        sss_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (in_acc && !s_axis_tuser),
            .i_clear (clear),
            .i_byte  (cell_in[g]),
            .i_want  (cell_want[g]),
            .i_care  (cell_care[g]),
            .o_byte  (cell_out[g]),
            .o_match (cell_match[g])
        );
    end

    always_comb begin
        logic              over;
        logic [POS_W-1:0]  p;
        logic [OFF_W-1:0]  p1;
        logic              more;
        logic              hit;
        logic [OFF_W-1:0]  ms;
        logic              a_emit, b_emit;
        logic [OFF_W-1:0]  a_start, a_len, a_idx;
        logic [OFF_W-1:0]  b_start, b_len, b_idx;
        t_result           res_a, res_b;

        n_off      = r_off;
        n_start    = r_start;
        n_tok      = r_tok;
        n_inside   = r_inside;
        n_mbc      = r_mbc;
        n_lns      = r_lns;
        n_limreach = r_limreach;
        a_emit     = 1'b0;
        b_emit     = 1'b0;
        a_start    = '0;
        a_len      = '0;
        a_idx      = '0;
        b_start    = '0;
        b_len      = '0;
        b_idx      = '0;
        hit        = 1'b0;
        ms         = '0;
        push       = '0;
        clear      = 1'b0;

        over       = r_off[OFF_W-1];
        p          = over ? POS_SAT : r_off[POS_W-1:0];
        p1         = {1'b0, p} + OFF_W'(1);
        more       = (r_limit == '0) || (({1'b0, r_tok} + 18'd1) < {2'b00, r_limit});
        n_off      = over ? r_off : r_off + OFF_W'(1);
        n_too_long = r_too_long || over;

        if (dlen == '0) begin
            if (s_axis_tdata != SPACE_BYTE) begin
                n_lns = p;
                if (!r_inside) begin
                    n_inside   = 1'b1;
                    n_start    = {1'b0, p};
                    n_limreach = !more;
                end
            end else if (r_inside && !r_limreach) begin
                a_emit   = 1'b1;
                a_start  = r_start;
                a_len    = {1'b0, p} - r_start;
                a_idx    = r_tok;
                n_tok    = tok_inc(r_tok);
                n_inside = 1'b0;
            end
            if (s_axis_tlast && n_inside) begin
                b_emit  = 1'b1;
                b_start = n_start;
                b_len   = {1'b0, n_lns} + OFF_W'(1) - n_start;
                b_idx   = n_tok;
                n_tok   = tok_inc(n_tok);
            end
        end else begin
            n_mbc = (r_mbc >= DLEN_W'(NUM_CELLS)) ? DLEN_W'(NUM_CELLS) : r_mbc + DLEN_W'(1);
            hit   = more && (n_mbc >= dlen) && (&cell_match);
            if (hit) begin
                ms      = (p1 >= OFF_W'(dlen)) ? p1 - OFF_W'(dlen) : '0;
                ms      = (ms < r_start) ? r_start : ms;
                a_emit  = 1'b1;
                a_start = r_start;
                a_len   = ms - r_start;
                a_idx   = r_tok;
                n_tok   = tok_inc(r_tok);
                n_start = p1;
                n_mbc   = '0;
            end
            if (s_axis_tlast) begin
                b_emit  = 1'b1;
                b_start = n_start;
                b_len   = (p1 >= n_start) ? p1 - n_start : '0;
                b_idx   = n_tok;
                n_tok   = tok_inc(n_tok);
            end
        end

        res_a = mk_token(1'b1, a_start, a_len, a_idx, n_too_long);
        res_b = mk_token(b_emit, b_start, b_len, b_idx, n_too_long);

        if (s_axis_tuser) begin
            push.count              = 2'd1;
            push.first              = mk_token(1'b0, '0, '0, '0, 1'b0);
            push.first.string_done  = 1'b1;
            push.first.last_of_run  = 1'b1;
            clear                   = in_acc;
        end else begin
            if (a_emit) begin
                push.first  = res_a;
                push.second = res_b;
                push.count  = b_emit ? 2'd2 : 2'd1;
            end else if (b_emit || s_axis_tlast) begin
                push.first  = res_b;
                push.count  = 2'd1;
            end
            if (push.count == 2'd2) begin
                push.second.last_of_run = 1'b1;
                if (s_axis_tlast) begin
                    push.second.string_done = 1'b1;
                    push.second.token_total = n_tok;
                end
            end else if (push.count == 2'd1) begin
                push.first.last_of_run = 1'b1;
                if (s_axis_tlast) begin
                    push.first.string_done = 1'b1;
                    push.first.token_total = n_tok;
                end
            end
            clear = in_acc && s_axis_tlast;
        end

        if (!in_acc) begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= '0;
            r_dlen  <= '0;
            r_limit <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DELIM_BYTES:  r_delim <= i_cfg_data;
                CFG_DELIM_LENGTH: r_dlen  <= i_cfg_data[DLEN_W-1:0];
                CFG_TOKEN_LIMIT:  r_limit <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear) begin
            r_off      <= '0;
            r_start    <= '0;
            r_tok      <= '0;
            r_inside   <= 1'b0;
            r_mbc      <= '0;
            r_lns      <= '0;
            r_limreach <= 1'b0;
            r_too_long <= 1'b0;
        end else if (in_acc) begin
            r_off      <= n_off;
            r_start    <= n_start;
            r_tok      <= n_tok;
            r_inside   <= n_inside;
            r_mbc      <= n_mbc;
            r_lns      <= n_lns;
            r_limreach <= n_limreach;
            r_too_long <= n_too_long;
        end
    end

    sss_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (m_axis_tready),
        .o_ready (q_ready),
        .o_valid (m_axis_tvalid),
        .o_data  (q_data)
    );

    assign m_axis_tdata = {5'b00000, q_data.last_of_run, q_data.token_total,
                           q_data.token_index, q_data.token_length, q_data.token_start};
    assign m_axis_tlast = q_data.string_done;
    assign m_axis_tuser = {q_data.too_long, q_data.token_valid};

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            m_axis_tdata[48:0] == 49'd0)
        else $error("result without token carries nonzero token fields");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[66])
        else $error("string done result is not last of its run");

    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (s_axis_tlast || s_axis_tuser) |=>
            r_off == '0 && r_tok == '0 && !r_inside && !r_too_long)
        else $error("string state not cleared after end of string");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.count != 2'd0 |-> q_ready)
        else $error("result pushed without queue room");

endmodule

[sim/string_splitter_stream_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for string_splitter_stream: directed strings and random strings
// under several idle/stall mixes, checked against an in-bench token predictor.
// Depends on sss_pkg and the string_splitter_stream RTL.
module string_splitter_stream_tb;
    import sss_pkg::*;

    localparam int unsigned STR_MAX   = 65536;
    localparam int unsigned DELIM_MAX = 8;
    localparam int unsigned TOKEN_CAP = 24'hFFFFFF;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [DELIM_W-1:0]    i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata  = '0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic [OUT_USER_W-1:0] m_axis_tuser;

    string_splitter_stream uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // predictor copy of configuration and per-string state
    logic [DELIM_W-1:0] cfg_delim = '0;
    int unsigned        cfg_dlen  = 0;
    int unsigned        cfg_limit = 0;
    logic [7:0]         win_bytes [8];
    int unsigned        str_pos, tok_begin, tok_count, since_start, last_solid;
    bit                 in_token, limit_hit, over_long;

    t_result expected_tokens [$];

    int errors        = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int tokens_seen   = 0;
    int strings_seen  = 0;
    int cfg_writes    = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        forever begin
            @(negedge i_clk);
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic int unsigned sat(int unsigned v, int unsigned hi);
        return (v > hi) ? hi : v;
    endfunction

    function automatic void clear_string();
        foreach (win_bytes[i]) win_bytes[i] = '0;
        str_pos     = 0;
        tok_begin   = 0;
        tok_count   = 0;
        in_token    = 1'b0;
        since_start = 0;
        last_solid  = 0;
        limit_hit   = 1'b0;
        over_long   = 1'b0;
    endfunction

    function automatic t_result token_rec(bit valid, int unsigned start, int unsigned len,
                                          int unsigned idx);
        t_result r;
        r = '0;
        if (valid) begin
            r.token_valid  = 1'b1;
            r.token_start  = POS_W'(sat(start, 65535));
            r.token_length = OFF_W'(sat(len, 65536));
            r.token_index  = POS_W'(sat(idx, 65535));
        end
        r.too_long = over_long;
        return r;
    endfunction

    function automatic bit more_allowed();
        return cfg_limit == 0 || tok_count + 1 < cfg_limit;
    endfunction

    function automatic void bump_count();
        if (tok_count < TOKEN_CAP) tok_count++;
    endfunction

    function automatic void split_predict(logic [7:0] b, bit eos, bit empty);
        t_result     res [$];
        t_result     r;
        int unsigned dlen, p, ms, len;
        bit          hit;
        dlen = sat(cfg_dlen, DELIM_MAX);
        if (empty) begin
            clear_string();
            r = token_rec(1'b0, 0, 0, 0);
            r.string_done = 1'b1;
            r.last_of_run = 1'b1;
            expected_tokens = {expected_tokens, r};
            return;
        end
        if (str_pos >= STR_MAX) begin
            over_long = 1'b1;
            p = STR_MAX - 1;
        end else begin
            p = str_pos;
            str_pos++;
        end
        for (int i = 7; i > 0; i--) win_bytes[i] = win_bytes[i-1];
        win_bytes[0] = b;
        if (dlen == 0) begin
            if (b != SPACE_BYTE) begin
                last_solid = p;
                if (!in_token) begin
                    in_token  = 1'b1;
                    tok_begin = p;
                    limit_hit = !more_allowed();
                end
            end else if (in_token && !limit_hit) begin
                res = {res, token_rec(1'b1, tok_begin, p - tok_begin, tok_count)};
                bump_count();
                in_token = 1'b0;
            end
            if (eos && in_token) begin
                len = last_solid + 1 - tok_begin;
                res = {res, token_rec(1'b1, tok_begin, len, tok_count)};
                bump_count();
            end
        end else begin
            since_start = sat(since_start + 1, DELIM_MAX);
            hit = more_allowed() && since_start >= dlen;
            for (int i = 0; hit && i < dlen; i++)
                if (win_bytes[dlen-1-i] != cfg_delim[8*i +: 8]) hit = 1'b0;
            if (hit) begin
                ms = (p + 1 >= dlen) ? p + 1 - dlen : 0;
                if (ms < tok_begin) ms = tok_begin;
                res = {res, token_rec(1'b1, tok_begin, ms - tok_begin, tok_count)};
                bump_count();
                tok_begin   = p + 1;
                since_start = 0;
            end
            if (eos) begin
                len = (p + 1 >= tok_begin) ? p + 1 - tok_begin : 0;
                res = {res, token_rec(1'b1, tok_begin, len, tok_count)};
                bump_count();
            end
        end
        if (eos) begin
            if (res.size() == 0) res = {res, token_rec(1'b0, 0, 0, 0)};
            res[$].string_done = 1'b1;
            res[$].token_total = OFF_W'(sat(tok_count, 65536));
            clear_string();
        end
        if (res.size() > 0) res[$].last_of_run = 1'b1;
        expected_tokens = {expected_tokens, res};
    endfunction

    function automatic void cmp_field(string name, logic [OFF_W-1:0] want, logic [OFF_W-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '0;
            got.token_valid  = m_axis_tuser[0];
            got.too_long     = m_axis_tuser[1];
            got.token_start  = m_axis_tdata[15:0];
            got.token_length = m_axis_tdata[32:16];
            got.token_index  = m_axis_tdata[48:33];
            got.token_total  = m_axis_tdata[65:49];
            got.last_of_run  = m_axis_tdata[66];
            got.string_done  = m_axis_tlast;
            results_seen++;
            if (got.token_valid) tokens_seen++;
            if (got.string_done) strings_seen++;
            if (expected_tokens.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, expected none, actual tdata %0h tuser %0h",
                         $time, m_axis_tdata, m_axis_tuser);
            end else begin
                want = expected_tokens.pop_front();
                cmp_field("token_valid", OFF_W'(want.token_valid), OFF_W'(got.token_valid));
                cmp_field("token_start", OFF_W'(want.token_start), OFF_W'(got.token_start));
                cmp_field("token_length", want.token_length, got.token_length);
                cmp_field("token_index", OFF_W'(want.token_index), OFF_W'(got.token_index));
                cmp_field("string_done", OFF_W'(want.string_done), OFF_W'(got.string_done));
                cmp_field("token_total", want.token_total, got.token_total);
                cmp_field("too_long", OFF_W'(want.too_long), OFF_W'(got.too_long));
                cmp_field("last_of_run", OFF_W'(want.last_of_run), OFF_W'(got.last_of_run));
            end
        end
    end

    task automatic send_item(logic [7:0] b, bit eos, bit empty);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eos;
        s_axis_tuser  <= empty;
        do @(posedge i_clk); while (!s_axis_tready);
        split_predict(b, eos, empty);
        items_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_item(s[i], i == s.len() - 1, 1'b0);
    endtask

    // hold the input idle until every expected result is out
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DELIM_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_DELIM_BYTES:  cfg_delim = data;
            CFG_DELIM_LENGTH: cfg_dlen  = 32'(data[3:0]);
            CFG_TOKEN_LIMIT:  cfg_limit = 32'(data[15:0]);
            default: ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_space_split();
        send_text(" ab  c ");
        send_text(" ");
        send_item(8'h00, 1'b0, 1'b1);
        send_item("x", 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);
    endtask

    task automatic test_delimiter_split();
        settle();
        write_reg(CFG_DELIM_BYTES, 64'h2C);
        write_reg(CFG_DELIM_LENGTH, DELIM_W'(1));
        send_text(",a,");
        settle();
        write_reg(CFG_DELIM_BYTES, 64'hFF00_FF00_FF00_FF00);
        write_reg(CFG_DELIM_LENGTH, DELIM_W'(15));
        write_reg(CFG_SPARE, '1);
        for (int i = 0; i < 8; i++) send_item(i[0] ? 8'hFF : 8'h00, i == 7, 1'b0);
    endtask

    task automatic test_token_limit();
        settle();
        write_reg(CFG_DELIM_LENGTH, DELIM_W'(0));
        write_reg(CFG_TOKEN_LIMIT, DELIM_W'(2));
        send_text("a b c ");
    endtask

    task automatic random_config();
        logic [DELIM_W-1:0] d;
        int unsigned        dl, lim;
        case ($urandom_range(4))
            0: d = '0;
            1: d = '1;
            2: d = {$urandom, $urandom};
            default: begin
                for (int i = 0; i < 8; i++)
                    case ($urandom_range(3))
                        0: d[8*i +: 8] = 8'h2C;
                        1: d[8*i +: 8] = 8'h3B;
                        2: d[8*i +: 8] = SPACE_BYTE;
                        default: d[8*i +: 8] = 8'h41;
                    endcase
            end
        endcase
        case ($urandom_range(5))
            0: dl = 0;
            1: dl = 1;
            2: dl = 8;
            3: dl = $urandom_range(9, 15);
            default: dl = $urandom_range(1, 7);
        endcase
        case ($urandom_range(5))
            0: lim = 0;
            1: lim = 1;
            2: lim = 65535;
            5: lim = $urandom_range(65535);
            default: lim = $urandom_range(2, 4);
        endcase
        write_reg(CFG_DELIM_BYTES, d);
        write_reg(CFG_DELIM_LENGTH, DELIM_W'(dl));
        write_reg(CFG_TOKEN_LIMIT, DELIM_W'(lim));
        if ($urandom_range(9) == 0) write_reg(CFG_SPARE, {$urandom, $urandom});
    endtask

    task automatic send_random_string();
        logic [7:0] bytes [$];
        int         target, dl, k, cut;
        dl = sat(cfg_dlen, DELIM_MAX);
        target = $urandom_range(1, 24);
        while (bytes.size() < target)
            case ($urandom_range(9))
                0, 1, 2: begin
                    if (dl == 0) repeat ($urandom_range(1, 3)) bytes = {bytes, SPACE_BYTE};
                    else for (k = 0; k < dl; k++) bytes = {bytes, cfg_delim[8*k +: 8]};
                end
                3: begin
                    cut = $urandom_range(0, dl);
                    for (k = 0; k < cut; k++) bytes = {bytes, cfg_delim[8*k +: 8]};
                    bytes = {bytes, 8'($urandom_range(255))};
                end
                4: bytes = {bytes, SPACE_BYTE};
                5, 6: bytes = {bytes, cfg_delim[8*$urandom_range(7) +: 8]};
                default: bytes = {bytes, 8'($urandom_range(255))};
            endcase
        if ($urandom_range(19) == 0) begin
            send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
            return;
        end
        cut = ($urandom_range(11) == 0) ? $urandom_range(bytes.size() - 1) : bytes.size();
        for (k = 0; k < cut; k++) send_item(bytes[k], k == bytes.size() - 1, 1'b0);
        if (cut < bytes.size()) send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
    endtask

    task automatic test_random(int send_pct, int stall_pct, int n_items);
        int goal;
        goal = items_sent + n_items;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        while (items_sent < goal) begin
            settle();
            random_config();
            repeat ($urandom_range(4, 12)) send_random_string();
        end
    endtask

    initial begin
        clear_string();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_space_split();
        test_delimiter_split();
        test_token_limit();
        test_random(0, 0, 375);
        test_random(58, 0, 375);
        test_random(0, 58, 375);
        test_random(17, 17, 375);

        settle();
        repeat (16) @(posedge i_clk);
        $display("Sent %0d input requests; checked %0d results, %0d tokens, %0d strings.",
                 items_sent, results_seen, tokens_seen, strings_seen);
        $display("Covered %0d register writes across space and delimiter modes, limits and stalls.",
                 cfg_writes);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
